// ----- src/assert_macros.svh -----
// Assertion macros shared by the downsampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bdpr_pkg.sv -----
// Shared types and constants of the packed RGB box downsampler.
`timescale 1ns / 1ps

package bdpr_pkg;

    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int BS_W      = 5;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

    localparam logic [BS_W-1:0]  RST_BLOCK_SIZE    = 5'd2;
    localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 12'd480;

    // Classification of one in-block pixel, made by the front end.
    typedef struct packed {
        logic col_first;
        logic col_last;
        logic row_first;
        logic row_last;
        logic last_of_frame;
    } t_work_ctl;

endpackage

// ----- src/bdpr_fifo.sv -----
// Small register-based FIFO used between the pipeline parts.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdpr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_go;
    logic             rd_go;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_go   = i_wr && !o_full;
    assign rd_go   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_go) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_go) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + 1'b1;
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, (!i_rst_n || r_count <= CNT_W'(DEPTH)), "FIFO count above depth")
    `ASSERT_CLK(a_count_up, i_clk, i_rst_n, (wr_go && !rd_go) |=> (r_count == $past(r_count) + 1'b1), "FIFO count did not follow a write")

endmodule

// ----- src/bdpr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bdpr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/bdpr_front.sv -----
// Front end: tracks the raster and block position and classifies each beat.
`timescale 1ns / 1ps

module bdpr_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_BLOCK = 16,
    localparam int MB = (MAX_BLOCK < 31) ? MAX_BLOCK : 31,
    localparam int BW = $clog2(MB),
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int CW = ($clog2(MAX_WIDTH + 1) > bdpr_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : bdpr_pkg::CFG_W,
    localparam int RW = bdpr_pkg::CFG_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic                       i_accept,
    input  logic [bdpr_pkg::BS_W-1:0]  i_block,
    input  logic [CW-1:0]              i_width,
    input  logic [RW-1:0]              i_height,
    input  logic [bdpr_pkg::PIX_W-1:0] i_pixel,
    output logic                       o_wr,
    output logic [bdpr_pkg::PIX_W-1:0] o_pixel,
    output bdpr_pkg::t_work_ctl        o_ctl,
    output logic [AW-1:0]              o_ocol
);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [BW-1:0] r_cib, n_cib;
    logic [BW-1:0] r_rib, n_rib;
    logic [AW-1:0] r_ocol, n_ocol;
    logic [CW-1:0] r_bcol, n_bcol;
    logic [RW-1:0] r_brow, n_brow;

    logic [CW+1:0]             bcol_end;
    logic [CW+1:0]             bcol_next_end;
    logic [RW+1:0]             brow_end;
    logic [RW+1:0]             brow_next_end;
    logic                      col_ok;
    logic                      row_ok;
    logic                      in_block;
    logic [bdpr_pkg::BS_W-1:0] d_m1;
    logic                      col_last;
    logic                      row_last;
    logic                      row_end;
    logic                      frame_end;

    always_comb begin
        bcol_end      = (CW+2)'(r_bcol) + (CW+2)'(i_block);
        bcol_next_end = bcol_end + (CW+2)'(i_block);
        brow_end      = (RW+2)'(r_brow) + (RW+2)'(i_block);
        brow_next_end = brow_end + (RW+2)'(i_block);
        col_ok        = bcol_end <= (CW+2)'(i_width);
        row_ok        = brow_end <= (RW+2)'(i_height);
        in_block      = col_ok && row_ok;
        d_m1          = i_block - 1'b1;
        col_last      = (bdpr_pkg::BS_W'(r_cib) == d_m1);
        row_last      = (bdpr_pkg::BS_W'(r_rib) == d_m1);
        row_end       = ((CW+1)'(r_col) + 1'b1) >= (CW+1)'(i_width);
        frame_end     = ((RW+1)'(r_row) + 1'b1) >= (RW+1)'(i_height);
    end

    assign o_wr                 = i_accept && in_block;
    assign o_pixel              = i_pixel;
    assign o_ocol               = r_ocol;
    assign o_ctl.col_first      = (r_cib == '0);
    assign o_ctl.col_last       = col_last;
    assign o_ctl.row_first      = (r_rib == '0);
    assign o_ctl.row_last       = row_last;
    assign o_ctl.last_of_frame  = (bcol_next_end > (CW+2)'(i_width)) &&
                                  (brow_next_end > (RW+2)'(i_height));

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_cib  = r_cib;
        n_rib  = r_rib;
        n_ocol = r_ocol;
        n_bcol = r_bcol;
        n_brow = r_brow;
        if (i_accept) begin
            if (in_block) begin
                if (col_last) begin
                    n_cib  = '0;
                    n_ocol = r_ocol + 1'b1;
                    n_bcol = r_bcol + CW'(i_block);
                end else begin
                    n_cib = r_cib + 1'b1;
                end
            end
            if (row_end) begin
                n_col  = '0;
                n_cib  = '0;
                n_ocol = '0;
                n_bcol = '0;
                n_row  = r_row + 1'b1;
                if (row_last) begin
                    n_rib  = '0;
                    n_brow = r_row + 1'b1;
                end else begin
                    n_rib = r_rib + 1'b1;
                end
                if (frame_end) begin
                    n_row  = '0;
                    n_rib  = '0;
                    n_brow = '0;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_cib  = '0;
            n_rib  = '0;
            n_ocol = '0;
            n_bcol = '0;
            n_brow = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cib  <= '0;
            r_rib  <= '0;
            r_ocol <= '0;
            r_bcol <= '0;
            r_brow <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_cib  <= n_cib;
            r_rib  <= n_rib;
            r_ocol <= n_ocol;
            r_bcol <= n_bcol;
            r_brow <= n_brow;
        end
    end

endmodule

// ----- src/bdpr_back.sv -----
// Back end: row sums, column line store, averaging divider and result hand-off.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdpr_back #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_BLOCK = 16,
    localparam int MB = (MAX_BLOCK < 31) ? MAX_BLOCK : 31,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int SW = $clog2(MB * MB * 255 + 1),
    localparam int NW = $clog2(MB * MB + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bdpr_pkg::BS_W-1:0]  i_block,
    input  logic                       i_item_valid,
    input  logic [bdpr_pkg::PIX_W-1:0] i_pixel,
    input  bdpr_pkg::t_work_ctl        i_ctl,
    input  logic [AW-1:0]              i_ocol,
    output logic                       o_item_pop,
    input  logic                       i_res_full,
    output logic                       o_res_push,
    output logic [bdpr_pkg::PIX_W-1:0] o_average_pixel,
    output logic                       o_last_of_frame
);

    localparam int NCH = bdpr_pkg::NUM_CH;
    localparam int CHW = bdpr_pkg::CH_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_PUSH
    } t_state;

    t_state            r_state, n_state;
    logic [SW-1:0]     r_rps [NCH];
    logic [SW-1:0]     n_rps [NCH];
    logic [NW-1:0]     r_rem [NCH];
    logic [NW-1:0]     n_rem [NCH];
    logic [CHW-1:0]    r_quo [NCH];
    logic [CHW-1:0]    n_quo [NCH];
    logic [2:0]        r_step, n_step;
    logic [AW-1:0]     r_ocol, n_ocol;
    logic              r_row_last, n_row_last;
    logic              r_lof, n_lof;

    logic [SW-1:0]     rsum    [NCH];
    logic [SW-1:0]     csum    [NCH];
    logic [SW-1:0]     div_src [NCH];
    logic [NW:0]       trial   [NCH];
    logic [NW-1:0]     n_div;
    logic              div_load;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [NCH*SW-1:0] ram_wdata;
    logic              ram_re;
    logic [NCH*SW-1:0] ram_rdata;

    bdpr_ram #(
        .WIDTH (NCH * SW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_ocol),
        .o_rdata (ram_rdata)
    );

    assign n_div = NW'({5'b0, i_block} * {5'b0, i_block});

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            rsum[c] = i_ctl.col_first ? SW'(i_pixel[c*CHW +: CHW]) :
                                        r_rps[c] + SW'(i_pixel[c*CHW +: CHW]);
            csum[c] = ram_rdata[c*SW +: SW] + r_rps[c];
            div_src[c] = (r_state == S_ACC) ? csum[c] : rsum[c];
            trial[c] = {r_rem[c], r_quo[c][CHW-1]};
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rps      = r_rps;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_step     = r_step;
        n_ocol     = r_ocol;
        n_row_last = r_row_last;
        n_lof      = r_lof;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = i_ocol;
        ram_wdata  = {rsum[2], rsum[1], rsum[0]};
        div_load   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_rps      = rsum;
                    if (i_ctl.col_last) begin
                        n_ocol     = i_ocol;
                        n_row_last = i_ctl.row_last;
                        n_lof      = i_ctl.last_of_frame;
                        if (i_ctl.row_first) begin
                            ram_we = 1'b1;
                            if (i_ctl.row_last) begin
                                div_load = 1'b1;
                            end
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_ACC;
                        end
                    end
                end
            end
            S_ACC: begin
                ram_we    = 1'b1;
                ram_waddr = r_ocol;
                ram_wdata = {csum[2], csum[1], csum[0]};
                if (r_row_last) begin
                    div_load = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                for (int c = 0; c < NCH; c++) begin
                    if (trial[c] >= {1'b0, n_div}) begin
                        n_rem[c] = NW'(trial[c] - {1'b0, n_div});
                        n_quo[c] = {r_quo[c][CHW-2:0], 1'b1};
                    end else begin
                        n_rem[c] = trial[c][NW-1:0];
                        n_quo[c] = {r_quo[c][CHW-2:0], 1'b0};
                    end
                end
                n_step = r_step + 1'b1;
                if (r_step == 3'd7) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The quotient fits in eight bits, so the top bits of the sum start as the remainder.
        if (div_load) begin
            for (int c = 0; c < NCH; c++) begin
                n_rem[c] = NW'(div_src[c] >> CHW);
                n_quo[c] = div_src[c][CHW-1:0];
            end
            n_step  = '0;
            n_state = S_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rps      <= n_rps;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_step     <= n_step;
        r_ocol     <= n_ocol;
        r_row_last <= n_row_last;
        r_lof      <= n_lof;
    end

    assign o_average_pixel = {r_quo[2], r_quo[1], r_quo[0]};
    assign o_last_of_frame = r_lof;

    `ASSERT_CLK(a_div_rem_range, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_rem[2] < n_div && r_rem[1] < n_div && r_rem[0] < n_div), "Divider remainder reached the divisor")
    `ASSERT_CLK(a_acc_from_idle, i_clk, i_rst_n, (r_state == S_ACC) |-> ($past(r_state) == S_IDLE), "Line store update did not follow a read")
    `ASSERT_CLK(a_push_after_div, i_clk, i_rst_n, (r_state == S_PUSH) |-> ($past(r_state) == S_DIV || $past(r_state) == S_PUSH), "Result stage entered without a division")

endmodule

// ----- src/box_downsample_packed_rgb_unit.sv -----
// Top level of the packed RGB box downsampler with its configuration registers.
`timescale 1ns / 1ps

// Box downsampler for packed RGB pixels in raster order. Each d by d block
// becomes one pixel whose channels are the floor of the block sums divided by
// d*d; trailing columns and rows that do not fill a block are dropped, and a
// configuration write to any of the three registers restarts the frame. The
// front end takes one pixel per clock, while its four-entry work queue is not
// full, and drops pixels outside whole blocks. The back end pops an in-block
// pixel; a right-most pixel of a block row below the first adds a line store
// read, then update; a bottom-right pixel adds the eight-step shared divider
// and the hand-off into a two-entry result queue, which waits while that queue
// is full. The line store holds MAX_WIDTH column sums, is never cleared, and
// needs no clearing pass.
module box_downsample_packed_rgb_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_BLOCK = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [bdpr_pkg::PIX_W-1:0]     i_source_pixel,
    output logic                           empty,
    input  logic                           pop,
    output logic [bdpr_pkg::PIX_W-1:0]     o_average_pixel,
    output logic                           o_last_of_frame,
    input  logic                           i_cfg_wr_en,
    input  logic [bdpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdpr_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int MB     = (MAX_BLOCK < 31) ? MAX_BLOCK : 31;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int CW     = ($clog2(MAX_WIDTH + 1) > bdpr_pkg::CFG_W) ?
                            $clog2(MAX_WIDTH + 1) : bdpr_pkg::CFG_W;
    localparam int CTL_W  = $bits(bdpr_pkg::t_work_ctl);
    localparam int WORK_W = bdpr_pkg::PIX_W + CTL_W + AW;
    localparam int RES_W  = bdpr_pkg::PIX_W + 1;

    logic [bdpr_pkg::BS_W-1:0]  r_block_size;
    logic [bdpr_pkg::CFG_W-1:0] r_source_width;
    logic [bdpr_pkg::CFG_W-1:0] r_source_height;
    logic                       restart;

    logic [bdpr_pkg::BS_W-1:0]  d_eff;
    logic [CW-1:0]              w_eff;
    logic [bdpr_pkg::CFG_W-1:0] h_eff;

    logic                       accept;
    logic                       front_wr;
    logic [bdpr_pkg::PIX_W-1:0] front_pixel;
    bdpr_pkg::t_work_ctl        front_ctl;
    logic [AW-1:0]              front_ocol;
    logic                       mid_full;
    logic                       mid_empty;
    logic                       mid_rd;
    logic [WORK_W-1:0]          mid_rdata;

    logic                       res_push;
    logic                       res_full;
    logic [bdpr_pkg::PIX_W-1:0] res_pixel;
    logic                       res_lof;
    logic [RES_W-1:0]           res_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size    <= bdpr_pkg::RST_BLOCK_SIZE;
            r_source_width  <= bdpr_pkg::RST_SOURCE_WIDTH;
            r_source_height <= bdpr_pkg::RST_SOURCE_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bdpr_pkg::REG_BLOCK_SIZE: begin
                    r_block_size <= i_cfg_data[bdpr_pkg::BS_W-1:0];
                end
                bdpr_pkg::REG_SOURCE_WIDTH: begin
                    r_source_width <= i_cfg_data;
                end
                bdpr_pkg::REG_SOURCE_HEIGHT: begin
                    r_source_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign restart = i_cfg_wr_en && (i_cfg_index == bdpr_pkg::REG_BLOCK_SIZE ||
                                     i_cfg_index == bdpr_pkg::REG_SOURCE_WIDTH ||
                                     i_cfg_index == bdpr_pkg::REG_SOURCE_HEIGHT);

    always_comb begin
        if (r_block_size == '0) begin
            d_eff = bdpr_pkg::BS_W'(1);
        end else if (int'(r_block_size) > MB) begin
            d_eff = bdpr_pkg::BS_W'(MB);
        end else begin
            d_eff = r_block_size;
        end
        if (r_source_width == '0) begin
            w_eff = CW'(1);
        end else if (int'(r_source_width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_source_width);
        end
        h_eff = (r_source_height == '0) ? bdpr_pkg::CFG_W'(1) : r_source_height;
    end

    assign full   = mid_full;
    assign accept = push && !mid_full;

    bdpr_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_accept  (accept),
        .i_block   (d_eff),
        .i_width   (w_eff),
        .i_height  (h_eff),
        .i_pixel   (i_source_pixel),
        .o_wr      (front_wr),
        .o_pixel   (front_pixel),
        .o_ctl     (front_ctl),
        .o_ocol    (front_ocol)
    );

    bdpr_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (4)
    ) u_work_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_wdata ({front_pixel, front_ctl, front_ocol}),
        .o_full  (mid_full),
        .i_rd    (mid_rd),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty)
    );

    bdpr_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_block         (d_eff),
        .i_item_valid    (!mid_empty),
        .i_pixel         (mid_rdata[WORK_W-1 -: bdpr_pkg::PIX_W]),
        .i_ctl           (bdpr_pkg::t_work_ctl'(mid_rdata[AW +: CTL_W])),
        .i_ocol          (mid_rdata[AW-1:0]),
        .o_item_pop      (mid_rd),
        .i_res_full      (res_full),
        .o_res_push      (res_push),
        .o_average_pixel (res_pixel),
        .o_last_of_frame (res_lof)
    );

    bdpr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata ({res_pixel, res_lof}),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign o_average_pixel = res_rdata[RES_W-1:1];
    assign o_last_of_frame = res_rdata[0];

endmodule
